>>> hdl/dqsi_pkg.sv
// ----------------------------------------------------------------------------
// Deque with sorted insert: shared package
// Sizes, command codes, beat types and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package dqsi_pkg;

	// Storage and field sizes; the beat types below are built on these.
	localparam int VALUE_BITS = 32;
	localparam int DEPTH      = 64;
	localparam int ADDR_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	// Command codes as seen on the request beat.
	localparam logic [2:0] CMD_ADD_BACK   = 3'd0;
	localparam logic [2:0] CMD_ADD_FRONT  = 3'd1;
	localparam logic [2:0] CMD_DROP_BACK  = 3'd2;
	localparam logic [2:0] CMD_DROP_FRONT = 3'd3;
	localparam logic [2:0] CMD_INSERT     = 3'd4;
	localparam logic [2:0] CMD_CLEAR      = 3'd5;
	localparam logic [2:0] CMD_PEEK       = 3'd6;

	// One request beat.
	typedef struct packed {
		logic [2:0]                   command;
		logic signed [VALUE_BITS-1:0] value;
	} req_beat_t;

	// One result beat.
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] front_value;
		logic signed [VALUE_BITS-1:0] back_value;
		logic                         is_empty;
		logic [CNT_BITS-1:0]          entry_count;
		logic                         overflow;
	} res_beat_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_OVF,
		OP_ADD_BACK,
		OP_ADD_FRONT,
		OP_DROP_BACK,
		OP_DROP_FRONT,
		OP_CLEAR,
		OP_SET_END,
		OP_RD_BACK,
		OP_CHK_BACK,
		OP_RD_IDX,
		OP_CHK_IDX,
		OP_SH_RD,
		OP_SH_WR,
		OP_INS_WR,
		OP_RD_FRONT,
		OP_RD_LAST,
		OP_EMIT
	} dp_op_t;

	// Status flags returned by the datapath.
	typedef struct packed {
		logic zero;    // no entries held
		logic full;    // all entries held
		logic ge;      // operand >= read data
		logic gt;      // read data > operand
		logic at_pos;  // walk index reached the insert position
	} dp_status_t;

endpackage

`default_nettype wire

>>> hdl/dqsi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dqsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; a read sees writes of earlier cycles.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/dqsi_dp.sv
// ----------------------------------------------------------------------------
// Deque with sorted insert: datapath
// Circular entry store with head pointer and count, walk index, compares and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqsi_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dqsi_pkg::dp_op_t   op,
	input  wire dqsi_pkg::req_beat_t request,
	output dqsi_pkg::dp_status_t    status,
	output logic                    done,
	output dqsi_pkg::res_beat_t     result
);

	import dqsi_pkg::*;

	logic [ADDR_BITS-1:0]         head_q;
	logic [CNT_BITS-1:0]          count_q;
	logic [CNT_BITS-1:0]          idx_q;
	logic [CNT_BITS-1:0]          pos_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic signed [VALUE_BITS-1:0] front_q;
	logic                         ovf_q;
	logic                         done_q;
	res_beat_t                    result_q;

	logic                         ram_we;
	logic [ADDR_BITS-1:0]         ram_waddr;
	logic [VALUE_BITS-1:0]        ram_wdata;
	logic [ADDR_BITS-1:0]         ram_raddr;
	logic [VALUE_BITS-1:0]        ram_rdata;
	logic signed [VALUE_BITS-1:0] rd_val;
	logic [ADDR_BITS-1:0]         head_dec;
	logic [ADDR_BITS-1:0]         head_inc;
	logic [CNT_BITS-1:0]          last_off;

	// Map a logical offset from the front onto a physical address.
	function automatic logic [ADDR_BITS-1:0] phys(input logic [ADDR_BITS-1:0] head,
		input logic [CNT_BITS-1:0] off);
		logic [ADDR_BITS:0] sum;
		sum = {1'b0, head} + (ADDR_BITS+1)'(off);
		if (sum >= (ADDR_BITS+1)'(DEPTH)) begin
			sum = sum - (ADDR_BITS+1)'(DEPTH);
		end
		return sum[ADDR_BITS-1:0];
	endfunction

	dqsi_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_val   = ram_rdata;
	assign head_dec = (head_q == '0) ? ADDR_BITS'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == ADDR_BITS'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign last_off = (count_q == '0) ? '0 : count_q - 1'b1;

	// Status back to the controller.
	assign status.zero   = (count_q == '0);
	assign status.full   = (count_q >= CNT_BITS'(DEPTH));
	assign status.ge     = (value_q >= rd_val);
	assign status.gt     = (rd_val > value_q);
	assign status.at_pos = (idx_q == pos_q);

	// Memory port steering per operation.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, idx_q);
		ram_wdata = value_q;
		ram_raddr = phys(head_q, idx_q);
		unique case (op)
			OP_ADD_BACK: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, count_q);
			end
			OP_ADD_FRONT: begin
				ram_we    = 1'b1;
				ram_waddr = head_dec;
			end
			OP_RD_BACK:  ram_raddr = phys(head_q, last_off);
			OP_SH_RD:    ram_raddr = phys(head_q, idx_q - 1'b1);
			OP_SH_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			OP_INS_WR:   ram_we = 1'b1;
			OP_RD_FRONT: ram_raddr = head_q;
			OP_RD_LAST:  ram_raddr = phys(head_q, last_off);
			default: begin
			end
		endcase
	end

	// Control registers: head pointer, count, overflow flag and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (op == OP_EMIT);
			unique case (op)
				OP_LOAD: ovf_q <= 1'b0;
				OP_OVF:  ovf_q <= 1'b1;
				OP_ADD_BACK, OP_INS_WR: count_q <= count_q + 1'b1;
				OP_ADD_FRONT: begin
					head_q  <= head_dec;
					count_q <= count_q + 1'b1;
				end
				OP_DROP_BACK: begin
					if (count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
				end
				OP_DROP_FRONT: begin
					if (count_q != '0) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				OP_CLEAR: count_q <= '0;
				default: begin
				end
			endcase
		end
	end

	// Payload registers: operand, walk index, insert position, front value, result.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: value_q <= request.value;
			OP_SET_END: begin
				idx_q <= count_q;
				pos_q <= count_q;
			end
			OP_CHK_BACK: begin
				if (value_q >= rd_val) begin
					idx_q <= count_q;
					pos_q <= count_q;
				end else begin
					idx_q <= '0;
				end
			end
			OP_CHK_IDX: begin
				if (rd_val > value_q) begin
					pos_q <= idx_q;
					idx_q <= count_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			OP_SH_WR:   idx_q <= idx_q - 1'b1;
			OP_RD_LAST: front_q <= rd_val;
			OP_EMIT: begin
				result_q.front_value <= (count_q == '0) ? '0 : front_q;
				result_q.back_value  <= (count_q == '0) ? '0 : rd_val;
				result_q.is_empty    <= (count_q == '0);
				result_q.entry_count <= count_q;
				result_q.overflow    <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> hdl/dqsi_ctrl.sv
// ----------------------------------------------------------------------------
// Deque with sorted insert: controller
// Sequences each command into datapath operations, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dqsi_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [2:0]           command,
	input  wire dqsi_pkg::dp_status_t status,
	output dqsi_pkg::dp_op_t          op,
	output logic                      busy
);

	import dqsi_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_B,
		ST_PUSH_F,
		ST_POP_B,
		ST_POP_F,
		ST_CLEAR,
		ST_INS_RB,
		ST_INS_CB,
		ST_SCAN_RD,
		ST_SCAN_CK,
		ST_SHIFT,
		ST_SHIFT_WR,
		ST_FIN_F,
		ST_FIN_B,
		ST_FIN_C
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// Next state and the operation for this cycle.
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op = OP_LOAD;
					unique case (command)
						CMD_ADD_BACK:   state_d = ST_PUSH_B;
						CMD_ADD_FRONT:  state_d = ST_PUSH_F;
						CMD_DROP_BACK:  state_d = ST_POP_B;
						CMD_DROP_FRONT: state_d = ST_POP_F;
						CMD_INSERT:     state_d = ST_INS_RB;
						CMD_CLEAR:      state_d = ST_CLEAR;
						default:        state_d = ST_FIN_F;
					endcase
				end
			end
			ST_PUSH_B: begin
				op      = status.full ? OP_OVF : OP_ADD_BACK;
				state_d = ST_FIN_F;
			end
			ST_PUSH_F: begin
				op      = status.full ? OP_OVF : OP_ADD_FRONT;
				state_d = ST_FIN_F;
			end
			ST_POP_B: begin
				op      = OP_DROP_BACK;
				state_d = ST_FIN_F;
			end
			ST_POP_F: begin
				op      = OP_DROP_FRONT;
				state_d = ST_FIN_F;
			end
			ST_CLEAR: begin
				op      = OP_CLEAR;
				state_d = ST_FIN_F;
			end
			// Full drops the insert; empty goes straight to the back.
			ST_INS_RB: begin
				if (status.full) begin
					op      = OP_OVF;
					state_d = ST_FIN_F;
				end else if (status.zero) begin
					op      = OP_SET_END;
					state_d = ST_SHIFT;
				end else begin
					op      = OP_RD_BACK;
					state_d = ST_INS_CB;
				end
			end
			ST_INS_CB: begin
				op      = OP_CHK_BACK;
				state_d = status.ge ? ST_SHIFT : ST_SCAN_RD;
			end
			// Look for the first entry from the front above the operand.
			ST_SCAN_RD: begin
				op      = OP_RD_IDX;
				state_d = ST_SCAN_CK;
			end
			ST_SCAN_CK: begin
				op      = OP_CHK_IDX;
				state_d = status.gt ? ST_SHIFT : ST_SCAN_RD;
			end
			// Move entries up one place from the back, then write the operand.
			ST_SHIFT: begin
				if (status.at_pos) begin
					op      = OP_INS_WR;
					state_d = ST_FIN_F;
				end else begin
					op      = OP_SH_RD;
					state_d = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				op      = OP_SH_WR;
				state_d = ST_SHIFT;
			end
			ST_FIN_F: begin
				op      = OP_RD_FRONT;
				state_d = ST_FIN_B;
			end
			ST_FIN_B: begin
				op      = OP_RD_LAST;
				state_d = ST_FIN_C;
			end
			ST_FIN_C: begin
				op      = OP_EMIT;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and registered busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

>>> hdl/deque_with_sorted_insert.sv
// ----------------------------------------------------------------------------
// Deque with sorted insert: top level
// Bounded double-ended queue of signed Q16.16 values with sorted insert.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its result beat
// appears on result for one cycle with done high, and must be captured then.
// A new command can be accepted in the cycle the result is shown.
// A push or insert on a full queue is dropped.
// A sorted insert into an empty queue, or one that lands at the back of a
// nonempty queue, writes the operand directly; otherwise the entries are
// searched and then moved one place each through the single read and write
// port of the entry memory.
// The entry memory needs no clearing after reset.
`default_nettype none

module deque_with_sorted_insert (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire dqsi_pkg::req_beat_t  request,
	output logic                      done,
	output dqsi_pkg::res_beat_t       result
);

	import dqsi_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	// Command sequencer.
	dqsi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(request.command),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	// Entry store and result register.
	dqsi_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.request(request),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

>>> hdl/dqsi_check.sv
// ----------------------------------------------------------------------------
// Deque with sorted insert: port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dqsi_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire dqsi_pkg::req_beat_t request,
	input wire logic                done,
	input wire dqsi_pkg::res_beat_t result
);

	import dqsi_pkg::*;

	// Every accepted command keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted beat");

	// A result beat only shows once the command has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Empty flag agrees with the count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.entry_count == '0)))
		else $error("empty flag and count disagree");

	// An empty queue reports zero at both ends.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |->
			(result.front_value == '0 && result.back_value == '0))
		else $error("nonzero end value on empty queue");

	// A dropped push or insert only happens on a full queue.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |-> (result.entry_count == CNT_BITS'(DEPTH)))
		else $error("overflow reported on a queue that is not full");

endmodule

bind deque_with_sorted_insert dqsi_check u_check (.*);

`default_nettype wire
